>>> hw/rtl/rgbhsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSL package
// Shared types, widths and codes for the RGB to HSL conversion pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int ChW  = 8;   // color channel width
  localparam int OutW = 16;  // hue / saturation / lightness width

  // Restoring divider geometry, one quotient bit per stage
  localparam int DivStages = 17;
  localparam int SatNumW   = 25;  // 2*d*65535 + den
  localparam int SatDenW   = 9;   // 2*den
  localparam int HueNumW   = 28;  // q*131072 + 6*d
  localparam int HueDenW   = 12;  // 12*d

  typedef struct packed {
    logic [ChW-1:0] red_in;
    logic [ChW-1:0] green_in;
    logic [ChW-1:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [OutW-1:0] hue_out;
    logic [OutW-1:0] saturation_out;
    logic [OutW-1:0] lightness_out;
    logic            gray_flag;
  } hsl_t;

  // Which channel is the maximum (ties go to red, then green)
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_e;

  // Values that bypass the dividers
  typedef struct packed {
    logic [OutW-1:0] lit;
    logic            gray;
  } side_t;

endpackage : rgbhsl_pkg
`default_nettype wire

>>> hw/rtl/rgbhsl_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, MSB first; caller guarantees num < den << QW.
// ----------------------------------------------------------------------------
module rgbhsl_div_pipe import rgbhsl_pkg::*; #(
  parameter int NW = HueNumW,
  parameter int DW = HueDenW,
  parameter int QW = DivStages
) (
  input  wire logic          clk_i,
  input  wire logic [QW-1:0] adv_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [QW-1:0] quo_nx;
    logic [W-1:0]  trial;
    logic          fits;

    if (j == 0) begin : g_first
      assign rem_in = W'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial  = W'(den_in) << (QW - 1 - j);
    assign fits   = (rem_in >= trial);
    assign quo_nx = quo_in | (QW'(fits) << (QW - 1 - j));

    always_ff @(posedge clk_i) begin
      if (adv_i[j]) begin
        rem_q[j] <= fits ? rem_in - trial : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_nx;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule : rgbhsl_div_pipe
`default_nettype wire

>>> hw/rtl/rgb_to_hsl_converter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per cycle, while the output is not stalled,
// into 16-bit hue, saturation and lightness plus a gray flag.
// ----------------------------------------------------------------------------
// Stages: min/max stage, operand stage, 17 divider stages, output register.
// Throughput: one pixel per cycle unless the output stalls; the two
// 17-stage restoring dividers set the depth. Bubbles collapse during a stall.
// Reset: asynchronous, clears every stage valid bit; data registers hold.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_unit import rgbhsl_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire pix_t in_req_i,

  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output hsl_t      out_req_o
);

  // Stage map: 0 = min/max, 1 = operands, 2..18 = divider, 19 = output
  localparam int NStg   = DivStages + 3;
  localparam int DivLo  = 2;
  localparam int OutStg = NStg - 1;

  logic [NStg-1:0] valid_q;
  logic [NStg-1:0] adv;

  // Advance a stage when it is empty or its content moves on
  assign adv[OutStg] = !valid_q[OutStg] || !out_stall_i;
  for (genvar k = 0; k < OutStg; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: find max/min, delta and sum
  // --------------------------------------------------------------------------
  logic [ChW-1:0] red, green, blue;
  logic           red_max, green_max;
  max_sel_e       sel_d;
  logic [ChW-1:0] mx, mn;

  assign red   = in_req_i.red_in;
  assign green = in_req_i.green_in;
  assign blue  = in_req_i.blue_in;

  assign red_max   = (red >= green) && (red >= blue);
  assign green_max = !red_max && (green >= blue);

  always_comb begin
    if (red_max) begin
      sel_d = SEL_RED;
      mx    = red;
    end else if (green_max) begin
      sel_d = SEL_GREEN;
      mx    = green;
    end else begin
      sel_d = SEL_BLUE;
      mx    = blue;
    end
  end

  assign mn = (red <= green) ? ((red <= blue) ? red : blue)
                             : ((green <= blue) ? green : blue);

  logic [ChW-1:0] r1_q, g1_q, b1_q, dlt1_q;
  logic [ChW:0]   sum1_q;
  max_sel_e       sel1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      r1_q   <= red;
      g1_q   <= green;
      b1_q   <= blue;
      dlt1_q <= mx - mn;
      sum1_q <= (ChW+1)'(mx) + (ChW+1)'(mn);
      sel1_q <= sel_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: build divider operands and lightness
  // --------------------------------------------------------------------------
  logic [ChW-1:0]     den;
  logic [10:0]        span;      // 6*d
  logic [10:0]        hue_pos;   // hue times 6*d, in [0, 6*d)
  logic [23:0]        sat_prod;  // d*65535
  logic [SatNumW-1:0] sat_num_d;
  logic [SatDenW-1:0] sat_den_d;
  logic [HueNumW-1:0] hue_num_d;
  logic [HueDenW-1:0] hue_den_d;
  logic [16:0]        lit_sum;   // s*257 + 1
  side_t              side_d;

  // Saturation denominator: s below half scale, else 510 - s
  always_comb begin
    if (sum1_q < 9'd255) begin
      den = sum1_q[ChW-1:0];
    end else begin
      den = ChW'(9'd510 - sum1_q);
    end
  end

  assign span = (11'(dlt1_q) << 2) + (11'(dlt1_q) << 1);

  always_comb begin
    unique case (sel1_q)
      SEL_RED: begin
        if (g1_q >= b1_q) begin
          hue_pos = 11'(g1_q) - 11'(b1_q);
        end else begin
          hue_pos = span - (11'(b1_q) - 11'(g1_q));
        end
      end
      SEL_GREEN: hue_pos = (11'(dlt1_q) << 1) + 11'(b1_q) - 11'(r1_q);
      SEL_BLUE:  hue_pos = (11'(dlt1_q) << 2) + 11'(r1_q) - 11'(g1_q);
      default:   hue_pos = '0;
    endcase
  end

  // Round half up: floor((2*num + den) / (2*den))
  assign sat_prod  = {dlt1_q, 16'h0000} - 24'(dlt1_q);
  assign sat_num_d = {sat_prod, 1'b0} + SatNumW'(den);
  assign sat_den_d = {den, 1'b0};
  assign hue_num_d = {hue_pos, 17'h00000} + HueNumW'(span);
  assign hue_den_d = {span, 1'b0};

  // 65535/510 is exactly 257/2, so lightness needs no divider
  assign lit_sum     = {sum1_q, 8'h00} + 17'(sum1_q) + 17'd1;
  assign side_d.lit  = lit_sum[16:1];
  assign side_d.gray = (dlt1_q == '0);

  logic [SatNumW-1:0] sat_num_q;
  logic [SatDenW-1:0] sat_den_q;
  logic [HueNumW-1:0] hue_num_q;
  logic [HueDenW-1:0] hue_den_q;
  side_t              side2_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sat_num_q <= sat_num_d;
      sat_den_q <= sat_den_d;
      hue_num_q <= hue_num_d;
      hue_den_q <= hue_den_d;
      side2_q   <= side_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..18: dividers, side values travel alongside
  // --------------------------------------------------------------------------
  logic [DivStages-1:0] div_adv;
  logic [DivStages-1:0] sat_quo, hue_quo;
  side_t                side_q [DivStages];

  assign div_adv = adv[DivLo +: DivStages];

  rgbhsl_div_pipe #(
    .NW (SatNumW),
    .DW (SatDenW),
    .QW (DivStages)
  ) u_sat_div (
    .clk_i (clk_i),
    .adv_i (div_adv),
    .num_i (sat_num_q),
    .den_i (sat_den_q),
    .quo_o (sat_quo)
  );

  rgbhsl_div_pipe #(
    .NW (HueNumW),
    .DW (HueDenW),
    .QW (DivStages)
  ) u_hue_div (
    .clk_i (clk_i),
    .adv_i (div_adv),
    .num_i (hue_num_q),
    .den_i (hue_den_q),
    .quo_o (hue_quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_adv[0]) begin
      side_q[0] <= side2_q;
    end
    for (int j = 1; j < DivStages; j++) begin
      if (div_adv[j]) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 19: output register; gray pixels force hue and saturation to zero
  // --------------------------------------------------------------------------
  hsl_t  out_d, out_q;
  side_t side_last;

  assign side_last = side_q[DivStages-1];

  // Hue never rounds up to a full turn, so the low bits are the wrapped value
  always_comb begin
    out_d.gray_flag      = side_last.gray;
    out_d.lightness_out  = side_last.lit;
    out_d.hue_out        = side_last.gray ? '0 : hue_quo[OutW-1:0];
    out_d.saturation_out = side_last.gray ? '0 : sat_quo[OutW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[OutStg]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[OutStg];
  assign out_req_o   = out_q;

endmodule : rgb_to_hsl_converter_unit
`default_nettype wire
